/* src/sbk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbk_pkg
// Shared types, widths and codes for the sorted byte-key node table.
// ----------------------------------------------------------------------------
package sbk_pkg;

    localparam int CAPACITY    = 16;
    localparam int HANDLE_BITS = 32;
    localparam int KEY_W       = 8;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int THR_W       = 4;
    localparam logic [THR_W-1:0] THR_RESET = 4'd3;

    localparam int POS_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input beat layout in s_tdata
    localparam int IN_KEY_LSB    = 0;
    localparam int IN_HANDLE_LSB = IN_KEY_LSB + KEY_W;
    localparam int IN_POS_LSB    = IN_HANDLE_LSB + HANDLE_BITS;
    localparam int IN_PV_LSB     = IN_POS_LSB + POS_W;
    localparam int IN_BITS       = IN_PV_LSB + 1;
    localparam int IN_DATA_W     = ((IN_BITS + 7) / 8) * 8;

    // result beat layout in m_tdata
    localparam int OUT_POS_LSB    = 0;
    localparam int OUT_KEY_LSB    = OUT_POS_LSB + POS_W;
    localparam int OUT_HANDLE_LSB = OUT_KEY_LSB + KEY_W;
    localparam int OUT_CNT_LSB    = OUT_HANDLE_LSB + HANDLE_BITS;
    localparam int OUT_SHRINK_LSB = OUT_CNT_LSB + CNT_W;
    localparam int OUT_BITS       = OUT_SHRINK_LSB + 1;
    localparam int OUT_DATA_W     = ((OUT_BITS + 7) / 8) * 8;

    // raw command codes on s_tuser
    localparam logic [CMD_W-1:0] CMD_EXACT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LBOUND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_EXACT  = 3'd0,
        OP_LBOUND = 3'd1,
        OP_INSERT = 3'd2,
        OP_ERASE  = 3'd3,
        OP_NEXT   = 3'd4,
        OP_READ   = 3'd5,
        OP_NOP    = 3'd6
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [KEY_W-1:0]       key;
        logic [HANDLE_BITS-1:0] handle;
        logic [POS_W-1:0]       pos;
        logic [CNT_W-1:0]       start_pos;   // slot a next-position step lands on
    } cmd_item_t;

endpackage

/* src/sorted_byte_key_node_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_byte_key_node_table
// Sorted table of up to 16 byte keys with child handles, one command a beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries commands: s_tuser = command code, s_tdata = key,
//   handle, position and position-valid flag. m_* channel returns one
//   result beat per command: m_tuser = status, m_tdata = position, key,
//   handle, entry count and shrink flag.
//   cfg_we/cfg_wdata write the shrink threshold; write only while idle.
//   Path from input beat to result beat: front register, queue slot,
//   table update with result register.
//   Throughput: one command per cycle while m_tready is high; the table
//   compares and shifts all 16 slots at once in the back end, which sets that rate.
//   Reset (aresetn low, synchronous) empties the table and the queue and
//   sets the threshold to 3. Key and handle slots are not cleared.
//   When m_tready is low the result register holds, the 2-entry queue and
//   the front register fill, then s_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module sorted_byte_key_node_table (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sbk_pkg::THR_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // key_byte, child_handle, position, position_valid, zero pad
    input  logic [sbk_pkg::IN_DATA_W-1:0]  s_tdata,
    // cmd
    input  logic [sbk_pkg::CMD_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found_position, found_key, found_handle, entry_count, shrink_advised, zero pad
    output logic [sbk_pkg::OUT_DATA_W-1:0] m_tdata,
    // status
    output logic [sbk_pkg::STATUS_W-1:0]   m_tuser
);
    import sbk_pkg::*;

    logic                   f_valid, f_ready;
    cmd_item_t              f_item;
    logic                   q_valid, q_ready;
    cmd_item_t              q_item;
    status_t                res_status;
    logic [POS_W-1:0]       res_pos;
    logic [KEY_W-1:0]       res_key;
    logic [HANDLE_BITS-1:0] res_handle;
    logic [CNT_W-1:0]       res_count;
    logic                   res_shrink;

    sbk_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item)
    );

    sbk_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    sbk_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_status (res_status),
        .res_pos    (res_pos),
        .res_key    (res_key),
        .res_handle (res_handle),
        .res_count  (res_count),
        .res_shrink (res_shrink)
    );

    assign m_tuser = res_status;
    assign m_tdata = OUT_DATA_W'({res_shrink, res_count, res_handle, res_key, res_pos});

endmodule

/* src/sbk_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbk_front
// Accepts input beats, decodes the command and holds it for the queue.
// ----------------------------------------------------------------------------
module sbk_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sbk_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [sbk_pkg::CMD_W-1:0]     s_tuser,
    output logic                          push_valid,
    input  logic                          push_ready,
    output sbk_pkg::cmd_item_t            push_item
);
    import sbk_pkg::*;

    logic      valid_reg, valid_next;
    cmd_item_t item_reg;
    cmd_item_t item_dec;
    logic      accept;

    assign s_tready   = !valid_reg || push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb begin
        item_dec.key    = s_tdata[IN_KEY_LSB +: KEY_W];
        item_dec.handle = s_tdata[IN_HANDLE_LSB +: HANDLE_BITS];
        item_dec.pos    = s_tdata[IN_POS_LSB +: POS_W];
        if (s_tdata[IN_PV_LSB]) begin
            item_dec.start_pos = CNT_W'(s_tdata[IN_POS_LSB +: POS_W]) + 1'b1;
        end else begin
            item_dec.start_pos = '0;
        end
        case (s_tuser)
            CMD_EXACT:  item_dec.op = OP_EXACT;
            CMD_LBOUND: item_dec.op = OP_LBOUND;
            CMD_INSERT: item_dec.op = OP_INSERT;
            CMD_ERASE:  item_dec.op = OP_ERASE;
            CMD_NEXT:   item_dec.op = OP_NEXT;
            CMD_READ:   item_dec.op = OP_READ;
            default:    item_dec.op = OP_NOP;
        endcase
    end

    assign valid_next = accept || (valid_reg && !push_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_dec;
        end
    end

endmodule

/* src/sbk_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbk_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module sbk_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  sbk_pkg::cmd_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output sbk_pkg::cmd_item_t pop_item
);
    import sbk_pkg::*;

    cmd_item_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/sbk_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbk_back
// Sorted key/handle table: executes one command per cycle unless the result stalls, result register.
// ----------------------------------------------------------------------------
module sbk_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sbk_pkg::THR_W-1:0]       cfg_wdata,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  sbk_pkg::cmd_item_t              pop_item,
    output logic                            res_valid,
    input  logic                            res_ready,
    output sbk_pkg::status_t                res_status,
    output logic [sbk_pkg::POS_W-1:0]       res_pos,
    output logic [sbk_pkg::KEY_W-1:0]       res_key,
    output logic [sbk_pkg::HANDLE_BITS-1:0] res_handle,
    output logic [sbk_pkg::CNT_W-1:0]       res_count,
    output logic                            res_shrink
);
    import sbk_pkg::*;

    logic [KEY_W-1:0]       key_reg    [CAPACITY];
    logic [KEY_W-1:0]       key_next   [CAPACITY];
    logic [HANDLE_BITS-1:0] handle_reg [CAPACITY];
    logic [HANDLE_BITS-1:0] handle_next[CAPACITY];
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [THR_W-1:0]       thr_reg;

    logic                   valid_reg, valid_next;
    status_t                status_reg, status_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [KEY_W-1:0]       rkey_reg, rkey_next;
    logic [HANDLE_BITS-1:0] rhandle_reg, rhandle_next;
    logic [CNT_W-1:0]       rcount_reg;
    logic                   shrink_reg, shrink_next;

    logic                   go;
    logic [CNT_W-1:0]       lt_cnt;
    logic                   lb_hit;
    logic [CNT_W-1:0]       pos_ext;
    logic                   pos_ok;
    logic                   do_insert, do_erase;

    assign pop_ready = !valid_reg || res_ready;
    assign go        = pop_valid && pop_ready;
    assign pos_ext   = CNT_W'(pop_item.pos);
    assign pos_ok    = pos_ext < count_reg;

    // keys are held sorted, so the lower bound is the number of smaller keys
    always_comb begin
        lt_cnt = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) < count_reg && key_reg[i] < pop_item.key) begin
                lt_cnt = lt_cnt + 1'b1;
            end
        end
    end

    assign lb_hit = lt_cnt < count_reg;

    always_comb begin
        status_next  = ST_MISS;
        pos_next     = '0;
        rkey_next    = '0;
        rhandle_next = '0;
        shrink_next  = 1'b0;
        do_insert    = 1'b0;
        do_erase     = 1'b0;
        count_next   = count_reg;
        case (pop_item.op)
            OP_EXACT: begin
                if (lb_hit && key_reg[lt_cnt[POS_W-1:0]] == pop_item.key) begin
                    status_next = ST_OK;
                    pos_next    = lt_cnt[POS_W-1:0];
                end
            end
            OP_LBOUND: begin
                if (lb_hit) begin
                    status_next = ST_OK;
                    pos_next    = lt_cnt[POS_W-1:0];
                end
            end
            OP_INSERT: begin
                if (count_reg == CNT_W'(CAPACITY)) begin
                    status_next = ST_FULL;
                end else begin
                    status_next = ST_OK;
                    pos_next    = lt_cnt[POS_W-1:0];
                    do_insert   = 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            OP_ERASE: begin
                if (!pos_ok) begin
                    status_next = ST_RANGE;
                end else begin
                    status_next = ST_OK;
                    do_erase    = 1'b1;
                    count_next  = count_reg - 1'b1;
                    shrink_next = CMP_W'(count_next) <= CMP_W'(thr_reg);
                end
            end
            OP_NEXT: begin
                if (pop_item.start_pos < count_reg) begin
                    status_next = ST_OK;
                    pos_next    = pop_item.start_pos[POS_W-1:0];
                end
            end
            OP_READ: begin
                if (!pos_ok) begin
                    status_next = ST_RANGE;
                end else begin
                    status_next  = ST_OK;
                    pos_next     = pop_item.pos;
                    rkey_next    = key_reg[pop_item.pos];
                    rhandle_next = handle_reg[pop_item.pos];
                end
            end
            default: begin
                status_next = ST_MISS;
            end
        endcase
    end

    // one-step shift of the whole row for insert and erase
    always_comb begin
        for (int j = 0; j < CAPACITY; j++) begin
            key_next[j]    = key_reg[j];
            handle_next[j] = handle_reg[j];
        end
        if (do_insert) begin
            for (int j = 1; j < CAPACITY; j++) begin
                if (CNT_W'(j) > lt_cnt) begin
                    key_next[j]    = key_reg[j-1];
                    handle_next[j] = handle_reg[j-1];
                end
            end
            key_next[lt_cnt[POS_W-1:0]]    = pop_item.key;
            handle_next[lt_cnt[POS_W-1:0]] = pop_item.handle;
        end
        if (do_erase) begin
            for (int j = 0; j < CAPACITY - 1; j++) begin
                if (CNT_W'(j) >= pos_ext) begin
                    key_next[j]    = key_reg[j+1];
                    handle_next[j] = handle_reg[j+1];
                end
            end
        end
    end

    assign valid_next = go || (valid_reg && !res_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            count_reg <= '0;
            thr_reg   <= THR_RESET;
        end else begin
            valid_reg <= valid_next;
            if (go) begin
                count_reg <= count_next;
            end
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            for (int j = 0; j < CAPACITY; j++) begin
                key_reg[j]    <= key_next[j];
                handle_reg[j] <= handle_next[j];
            end
            status_reg  <= status_next;
            pos_reg     <= pos_next;
            rkey_reg    <= rkey_next;
            rhandle_reg <= rhandle_next;
            rcount_reg  <= count_next;
            shrink_reg  <= shrink_next;
        end
    end

    assign res_valid  = valid_reg;
    assign res_status = status_reg;
    assign res_pos    = pos_reg;
    assign res_key    = rkey_reg;
    assign res_handle = rhandle_reg;
    assign res_count  = rcount_reg;
    assign res_shrink = shrink_reg;

endmodule

/* src/sbk_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbk_checker
// Port-level checks on the result channel of the node table.
// ----------------------------------------------------------------------------
module sbk_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [sbk_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic [sbk_pkg::STATUS_W-1:0]   m_tuser
);
    import sbk_pkg::*;

    logic [CNT_W-1:0]       chk_count;
    logic [KEY_W-1:0]       chk_key;
    logic [HANDLE_BITS-1:0] chk_handle;
    logic                   chk_shrink;

    assign chk_count  = m_tdata[OUT_CNT_LSB +: CNT_W];
    assign chk_key    = m_tdata[OUT_KEY_LSB +: KEY_W];
    assign chk_handle = m_tdata[OUT_HANDLE_LSB +: HANDLE_BITS];
    assign chk_shrink = m_tdata[OUT_SHRINK_LSB];

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_FULL |-> chk_count == CNT_W'(CAPACITY))
        else $error("full reported below capacity");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> chk_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> chk_key == '0 && chk_handle == '0 && !chk_shrink)
        else $error("failed command returned data");

endmodule

bind sorted_byte_key_node_table sbk_checker u_sbk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
